>>> hw/rtl/lrast_pkg.sv
// Shared types and constants for the line rasterizer.
package lrast_pkg;

  // Item kind carried on s_tuser
  localparam logic KIND_START    = 1'b0;
  localparam logic KIND_CONTINUE = 1'b1;

  // Configuration register file
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_LINE_PITCH = 2'd2;

  localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH    = 15'd1024;
  localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT   = 15'd768;
  localparam logic [CFG_W-1:0] RST_SCAN_LINE_PITCH = 15'd1024;

  // Stream word widths
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 96;
  localparam int OFFSET_W   = 28;

  typedef struct packed {
    logic [CFG_W-1:0] screen_width;
    logic [CFG_W-1:0] screen_height;
    logic [CFG_W-1:0] scan_line_pitch;
  } cfg_t;

endpackage

>>> hw/rtl/line_rasterizer_core.sv
// Bresenham line rasterizer: pixel stepper, clip test and framebuffer offset.
//
// Usage:
//   Input words arrive on s_*. s_tuser[0] selects the kind: start loads both
//   endpoints and the colour from s_tdata and yields the first pixel; continue
//   takes one Bresenham step and yields the next pixel. After the endpoint,
//   continue words repeat the end position with no write and tlast set.
//   Each input word gives exactly one output word on m_*: coordinates, the
//   word offset y*pitch+x (zero when clipped), the colour, the write enable
//   on m_tuser[0] and the endpoint flag on m_tlast. Config regs (width,
//   height, pitch) are written through cfg_we/cfg_index/cfg_data; index 3
//   is ignored. The user must write them only while idle (not enforced).
// Timing:
//   One word per clock while the output is not stalled: each pixel is one
//   compare-add step of the error and position. An accepted word reaches m_*
//   via stage 1 (the stepped pixel) and stage 2 (clip and 15x15 offset).
// Reset (rst, synchronous): pipeline empty, no line active (a continue before
//   any start reports pixel 0,0 with no write), config 1024x768, pitch 1024.
// Stall: with m_tready low the output word holds; stage 1 still fills, and
//   s_tready drops only once both stages are full.
module line_rasterizer_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: x_start[15:0], y_start[31:16], x_end[47:32], y_end[63:48],
  //          line_colour[95:64]
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lrast_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [0:0]                          s_tuser,   // kind[0]
  // m_tdata: pixel_x[15:0], pixel_y[31:16], pixel_offset[59:32],
  //          pixel_value[91:60], zero pad[95:92]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lrast_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [0:0]                          m_tuser,   // write_enable[0]
  output logic                                m_tlast,   // last
  // config write port
  input  logic                                cfg_we,
  input  logic [lrast_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrast_pkg::CFG_W-1:0]         cfg_data
);

  localparam int C      = COORD_BITS;
  localparam int DW     = C + 1;                  // abs delta width
  localparam int EW     = C + 3;                  // error term width
  localparam int XW     = (C > 16) ? C : 16;      // sign-extended coord width
  localparam int CMP_W  = ((C > 15) ? C : 15) + 1;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  lrast_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width    <= lrast_pkg::RST_SCREEN_WIDTH;
      cfg.screen_height   <= lrast_pkg::RST_SCREEN_HEIGHT;
      cfg.scan_line_pitch <= lrast_pkg::RST_SCAN_LINE_PITCH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrast_pkg::REG_SCREEN_WIDTH:    cfg.screen_width    <= cfg_data;
        lrast_pkg::REG_SCREEN_HEIGHT:   cfg.screen_height   <= cfg_data;
        lrast_pkg::REG_SCAN_LINE_PITCH: cfg.scan_line_pitch <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: two-stage pipe, each stage advances when the next has room
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic s2_ready;
  logic in_fire;

  assign s2_ready = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s2_ready;
  assign in_fire  = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Line state
  // ---------------------------------------------------------------------------
  logic signed [C-1:0]  cur_x, cur_y, target_x, target_y;
  logic        [DW-1:0] abs_dx, abs_dy;
  logic                 step_neg_x, step_neg_y;
  logic signed [EW-1:0] error_term;
  logic        [31:0]   held_colour;
  logic                 finished;

  logic signed [C-1:0]  cur_x_next, cur_y_next, target_x_next, target_y_next;
  logic        [DW-1:0] abs_dx_next, abs_dy_next;
  logic                 step_neg_x_next, step_neg_y_next;
  logic signed [EW-1:0] error_term_next;
  logic        [31:0]   held_colour_next;
  logic                 finished_next;
  logic                 allow_next;

  // input fields, wrapped/extended to the coordinate width
  logic signed [C-1:0]  in_x0, in_y0, in_x1, in_y1;
  logic signed [DW-1:0] diff_x, diff_y;
  logic signed [EW:0]   e2;
  logic                 step_x, step_y;
  logic                 is_start;

  assign is_start = (s_tuser[0] == lrast_pkg::KIND_START);
  assign in_x0 = C'($signed(s_tdata[15:0]));
  assign in_y0 = C'($signed(s_tdata[31:16]));
  assign in_x1 = C'($signed(s_tdata[47:32]));
  assign in_y1 = C'($signed(s_tdata[63:48]));
  assign diff_x = DW'(in_x1) - DW'(in_x0);
  assign diff_y = DW'(in_y1) - DW'(in_y0);

  // doubled error against -dy (x step) and dx (y step)
  assign e2     = {error_term, 1'b0};
  assign step_x = e2 > -$signed((EW+1)'(abs_dy));
  assign step_y = e2 < $signed((EW+1)'(abs_dx));

  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    target_x_next    = target_x;
    target_y_next    = target_y;
    abs_dx_next      = abs_dx;
    abs_dy_next      = abs_dy;
    step_neg_x_next  = step_neg_x;
    step_neg_y_next  = step_neg_y;
    error_term_next  = error_term;
    held_colour_next = held_colour;
    finished_next    = finished;
    allow_next       = 1'b0;
    if (is_start) begin
      cur_x_next       = in_x0;
      cur_y_next       = in_y0;
      target_x_next    = in_x1;
      target_y_next    = in_y1;
      abs_dx_next      = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
      abs_dy_next      = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
      step_neg_x_next  = !(in_x0 < in_x1);
      step_neg_y_next  = !(in_y0 < in_y1);
      error_term_next  = $signed(EW'(abs_dx_next)) - $signed(EW'(abs_dy_next));
      held_colour_next = s_tdata[95:64];
      finished_next    = (in_x0 == in_x1) && (in_y0 == in_y1);
      allow_next       = 1'b1;
    end else if (!finished) begin
      if (step_x) begin
        cur_x_next = step_neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (step_y) begin
        cur_y_next = step_neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      error_term_next = error_term
                      - (step_x ? $signed(EW'(abs_dy)) : EW'(0))
                      + (step_y ? $signed(EW'(abs_dx)) : EW'(0));
      finished_next   = (cur_x_next == target_x) && (cur_y_next == target_y);
      allow_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      abs_dx      <= '0;
      abs_dy      <= '0;
      step_neg_x  <= 1'b0;
      step_neg_y  <= 1'b0;
      error_term  <= '0;
      held_colour <= '0;
      finished    <= 1'b1;
    end else if (in_fire) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      target_x    <= target_x_next;
      target_y    <= target_y_next;
      abs_dx      <= abs_dx_next;
      abs_dy      <= abs_dy_next;
      step_neg_x  <= step_neg_x_next;
      step_neg_y  <= step_neg_y_next;
      error_term  <= error_term_next;
      held_colour <= held_colour_next;
      finished    <= finished_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 pixel register
  // ---------------------------------------------------------------------------
  logic signed [C-1:0] p1_x, p1_y;
  logic        [31:0]  p1_colour;
  logic                p1_allow, p1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_x      <= cur_x_next;
      p1_y      <= cur_y_next;
      p1_colour <= held_colour_next;
      p1_allow  <= allow_next;
      p1_last   <= finished_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: clip test and offset multiply
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0]          ux, uy;
  logic                      on_screen;
  logic [29:0]               prod;
  logic [30:0]               offset_sum;
  logic [lrast_pkg::OFFSET_W-1:0] offset;
  logic signed [XW-1:0]      ext_x, ext_y;

  assign ux        = CMP_W'(p1_x);
  assign uy        = CMP_W'(p1_y);
  assign on_screen = p1_allow && !p1_x[C-1] && !p1_y[C-1]
                  && (ux < CMP_W'(cfg.screen_width))
                  && (uy < CMP_W'(cfg.screen_height));
  // on-screen coordinates are below the 15-bit limits
  assign prod       = uy[14:0] * cfg.scan_line_pitch;
  assign offset_sum = 31'(prod) + 31'(ux[14:0]);
  assign offset     = on_screen ? offset_sum[lrast_pkg::OFFSET_W-1:0] : '0;
  assign ext_x      = XW'(p1_x);
  assign ext_y      = XW'(p1_y);

  logic [15:0]                    out_x, out_y;
  logic [lrast_pkg::OFFSET_W-1:0] out_offset;
  logic [31:0]                    out_colour;
  logic                           out_we, out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_ready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_x      <= ext_x[15:0];
      out_y      <= ext_y[15:0];
      out_offset <= offset;
      out_colour <= p1_colour;
      out_we     <= on_screen;
      out_last   <= p1_last;
    end
  end

  assign m_tdata    = {4'b0000, out_colour, out_offset, out_y, out_x};
  assign m_tuser[0] = out_we;
  assign m_tlast    = out_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // continue on a finished line: no write, endpoint flagged
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser[0] == lrast_pkg::KIND_CONTINUE && finished)
      |=> (s1_valid && p1_last && !p1_allow))
    else $error("continue after end must give last without write");

  // single-point line finishes at once
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_start && in_x0 == in_x1 && in_y0 == in_y1)
      |=> (finished && p1_last))
    else $error("single-point line must end on its start pixel");

  // a written pixel is never at a negative coordinate
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_we) |-> (!out_x[15] && !out_y[15]))
    else $error("write enabled for negative coordinate");

  // stage 1 word is not dropped while the output stalls
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_ready) |=> (s1_valid && $stable(p1_x) && $stable(p1_y)))
    else $error("stage 1 word lost under stall");

  // clipped pixels carry a zero offset
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_we) |-> (out_offset == '0))
    else $error("offset must be zero for a clipped pixel");

endmodule
